### src/scps_pkg.sv
package scps_pkg;

  localparam int POINTS    = 5;
  localparam int PROFILES  = 2;
  localparam int TBL_DEPTH = POINTS * PROFILES;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int SEG_W     = (POINTS > 2) ? $clog2(POINTS - 1) : 1;
  localparam int MULT_W    = 16 + $clog2(POINTS);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // ratio divider: (rem << 17) + step over 2*step
  localparam int RATIO_W = 32;
  localparam int ACC1_W  = 34;
  localparam int DEN1_W  = 17;
  localparam int CMP1_W  = DEN1_W + RATIO_W;

  // bounds and percent divider
  localparam int BND_W   = 47;
  localparam int DIFF_W  = 48;
  localparam int NUM_W   = 57;
  localparam int DEN2_W  = DIFF_W + 1;
  localparam int QUO_W   = 16;
  localparam int CMP2_W  = DEN2_W + QUO_W + 1;

  localparam logic [15:0] SUPPLY_START_RST = 16'd10000;
  localparam logic [15:0] SUPPLY_STEP_RST  = 16'd1000;
  localparam logic [15:0] SUPPLY_END_RST   = 16'd14000;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [1:0] {
    CFG_SUPPLY_START = 2'd0,
    CFG_SUPPLY_STEP  = 2'd1,
    CFG_SUPPLY_END   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        op;
    logic        profile;
    logic [2:0]  point;
    logic [12:0] cal_low_mv;
    logic [12:0] cal_high_mv;
    logic [12:0] sensor_mv;
    logic [15:0] supply_mv;
  } scps_in_t;

  typedef struct packed {
    logic signed [15:0] percent;
    logic               saturated;
    logic               degenerate;
  } scps_out_t;

  typedef struct packed {
    logic [15:0] supply_start_mv;
    logic [15:0] supply_step_mv;
    logic [15:0] supply_end_mv;
  } scps_cfg_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [12:0] sensor;
    logic [12:0] la;
    logic [12:0] lb;
    logic [12:0] ha;
    logic [12:0] hb;
  } scps_item_t;

endpackage

### src/scps_front.sv
module scps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scps_pkg::scps_in_t  in_data,
  input  scps_pkg::scps_cfg_t cfg,
  output logic                push_valid,
  input  logic                push_ready,
  output scps_pkg::scps_item_t push_data
);
  import scps_pkg::*;

  logic              f1_v_r;
  logic [15:0]       f1_offset_r;
  logic [12:0]       f1_sensor_r;
  logic              f1_prof_r;

  logic              f2_v_r;
  logic [15:0]       f2_rem_r;
  logic [12:0]       f2_sensor_r;
  logic              f2_prof_ok_r;
  logic [12:0]       f2_la_r, f2_lb_r, f2_ha_r, f2_hb_r;

  logic [12:0]       low_mem  [TBL_DEPTH];
  logic [12:0]       high_mem [TBL_DEPTH];

  logic [15:0]       step_eff;
  logic [15:0]       supply_c;
  logic [15:0]       offset_nxt;
  logic [15:0]       rem_nxt;
  logic [SEG_W-1:0]  seg;
  logic              prof_ok;
  logic              ld_ok;
  logic              ld_en;
  logic              f2_ready;
  logic [ADDR_W-1:0] rd_addr0, rd_addr1, wr_addr;

  assign f2_ready = !f2_v_r || push_ready;
  assign in_ready = !f1_v_r || f2_ready;

  always_comb begin
    step_eff = (cfg.supply_step_mv == '0) ? 16'd1 : cfg.supply_step_mv;
    if (in_data.supply_mv < cfg.supply_start_mv) begin
      supply_c = cfg.supply_start_mv;
    end else if (in_data.supply_mv > cfg.supply_end_mv) begin
      supply_c = cfg.supply_end_mv;
    end else begin
      supply_c = in_data.supply_mv;
    end
    offset_nxt = (supply_c >= cfg.supply_start_mv) ? supply_c - cfg.supply_start_mv : '0;
  end

  // segment search: highest k, at most POINTS-2, with k*step <= offset
  always_comb begin
    logic [MULT_W-1:0] mult;
    mult    = '0;
    seg     = '0;
    rem_nxt = f1_offset_r;
    for (int k = 1; k <= POINTS - 2; k++) begin
      mult = MULT_W'(k) * MULT_W'(step_eff);
      if (MULT_W'(f1_offset_r) >= mult) begin
        seg     = SEG_W'(k);
        rem_nxt = f1_offset_r - mult[15:0];
      end
    end
  end

  always_comb begin
    prof_ok  = int'(f1_prof_r) < PROFILES;
    rd_addr0 = prof_ok ? ADDR_W'(int'(f1_prof_r) * POINTS + int'(seg)) : '0;
    rd_addr1 = rd_addr0 + ADDR_W'(1);
    ld_ok    = (int'(in_data.profile) < PROFILES) && (int'(in_data.point) < POINTS);
    wr_addr  = ADDR_W'(int'(in_data.profile) * POINTS + int'(in_data.point));
    ld_en    = in_valid && in_ready && (in_data.op == OP_LOAD) && ld_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        f1_v_r <= in_valid && (in_data.op == OP_CONVERT);
      end
      if (f2_ready) begin
        f2_v_r <= f1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      f1_offset_r <= offset_nxt;
      f1_sensor_r <= in_data.sensor_mv;
      f1_prof_r   <= in_data.profile;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      low_mem[wr_addr]  <= in_data.cal_low_mv;
      high_mem[wr_addr] <= in_data.cal_high_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_ready) begin
      f2_rem_r     <= rem_nxt;
      f2_sensor_r  <= f1_sensor_r;
      f2_prof_ok_r <= prof_ok;
      f2_la_r      <= low_mem[rd_addr0];
      f2_lb_r      <= low_mem[rd_addr1];
      f2_ha_r      <= high_mem[rd_addr0];
      f2_hb_r      <= high_mem[rd_addr1];
    end
  end

  assign push_valid       = f2_v_r;
  assign push_data.rem    = f2_rem_r;
  assign push_data.sensor = f2_sensor_r;
  assign push_data.la     = f2_prof_ok_r ? f2_la_r : '0;
  assign push_data.lb     = f2_prof_ok_r ? f2_lb_r : '0;
  assign push_data.ha     = f2_prof_ok_r ? f2_ha_r : '0;
  assign push_data.hb     = f2_prof_ok_r ? f2_hb_r : '0;

  a_f1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f1_v_r && !f2_ready |=> f1_v_r && $stable(f1_offset_r))
    else $error("front stage lost a stalled request");

endmodule

### src/scps_queue.sv
module scps_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  scps_pkg::scps_item_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output scps_pkg::scps_item_t pop_data
);
  import scps_pkg::*;

  scps_item_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            push, pop;

  assign push_ready = count_r != Q_CW'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue count overflow");

  a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + Q_CW'(1))
    else $error("queue count did not follow push");

endmodule

### src/scps_back.sv
module scps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scps_pkg::scps_item_t in_item,
  input  logic [15:0]          step,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scps_pkg::scps_out_t  out_data
);
  import scps_pkg::*;

  typedef struct packed {
    logic [ACC1_W-1:0]  acc;
    logic [RATIO_W-1:0] quo;
    logic [12:0]        sensor;
    logic [12:0]        la;
    logic [12:0]        lb;
    logic [12:0]        ha;
    logic [12:0]        hb;
  } d1_t;

  typedef struct packed {
    logic signed [BND_W-1:0] lo;
    logic signed [BND_W-1:0] hi;
    logic [12:0]             sensor;
  } bnd_t;

  typedef struct packed {
    logic              neg;
    logic              degen;
    logic [DIFF_W-1:0] mag;
    logic [DIFF_W-1:0] den;
  } cls_t;

  typedef struct packed {
    logic [NUM_W-1:0]  acc;
    logic [QUO_W-1:0]  quo;
    logic [DEN2_W-1:0] den2;
    logic              ovf;
    logic              neg;
    logic              degen;
  } d2_t;

  localparam logic [15:0] PCT_MAX = 16'h7FFF;
  localparam logic [15:0] PCT_MIN = 16'h8000;

  logic              adv;
  logic [15:0]       step_eff;
  logic [DEN1_W-1:0] den1;

  d1_t             d1_in;
  d1_t             d1_r   [RATIO_W+1];
  d1_t             d1_nxt [RATIO_W];
  logic [RATIO_W:0] d1_v_r;

  bnd_t bnd_nxt, bnd_r;
  logic bnd_v_r;
  cls_t cls_nxt, cls_r;
  logic cls_v_r;

  d2_t             d2_in;
  d2_t             d2_r   [QUO_W+1];
  d2_t             d2_nxt [QUO_W];
  logic [QUO_W:0]  d2_v_r;

  scps_out_t out_nxt, out_r;
  logic      out_v_r;

  assign adv       = !out_v_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign step_eff = (step == '0) ? 16'd1 : step;
  assign den1     = {step_eff, 1'b0};

  always_comb begin
    d1_in.acc    = ACC1_W'({in_item.rem, 17'b0}) + ACC1_W'(step_eff);
    d1_in.quo    = '0;
    d1_in.sensor = in_item.sensor;
    d1_in.la     = in_item.la;
    d1_in.lb     = in_item.lb;
    d1_in.ha     = in_item.ha;
    d1_in.hb     = in_item.hb;
  end

  always_comb begin
    logic [CMP1_W-1:0] dsh;
    dsh = '0;
    for (int i = 0; i < RATIO_W; i++) begin
      d1_nxt[i] = d1_r[i];
      dsh = CMP1_W'(den1) << (RATIO_W - 1 - i);
      if (CMP1_W'(d1_r[i].acc) >= dsh) begin
        d1_nxt[i].acc = ACC1_W'(CMP1_W'(d1_r[i].acc) - dsh);
        d1_nxt[i].quo[RATIO_W-1-i] = 1'b1;
      end
    end
  end

  always_comb begin
    logic signed [13:0]      dl, dh;
    logic signed [BND_W-1:0] r_x, dl_x, dh_x, la_x, ha_x;
    dl   = $signed({1'b0, d1_r[RATIO_W].lb}) - $signed({1'b0, d1_r[RATIO_W].la});
    dh   = $signed({1'b0, d1_r[RATIO_W].hb}) - $signed({1'b0, d1_r[RATIO_W].ha});
    r_x  = BND_W'($signed({1'b0, d1_r[RATIO_W].quo}));
    dl_x = BND_W'(dl);
    dh_x = BND_W'(dh);
    la_x = BND_W'({d1_r[RATIO_W].la, 16'b0});
    ha_x = BND_W'({d1_r[RATIO_W].ha, 16'b0});
    bnd_nxt.lo     = la_x + r_x * dl_x;
    bnd_nxt.hi     = ha_x + r_x * dh_x;
    bnd_nxt.sensor = d1_r[RATIO_W].sensor;
  end

  always_comb begin
    logic signed [DIFF_W-1:0] s_x, lo_x, hi_x, x, dn;
    logic                     rising;
    s_x    = DIFF_W'({bnd_r.sensor, 16'b0});
    lo_x   = DIFF_W'(bnd_r.lo);
    hi_x   = DIFF_W'(bnd_r.hi);
    rising = bnd_r.hi > bnd_r.lo;
    x      = rising ? s_x - lo_x : lo_x - s_x;
    dn     = rising ? hi_x - lo_x : lo_x - hi_x;
    cls_nxt.degen = bnd_r.hi == bnd_r.lo;
    cls_nxt.neg   = x[DIFF_W-1];
    cls_nxt.mag   = x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
    cls_nxt.den   = DIFF_W'(dn);
  end

  always_comb begin
    d2_in.acc   = NUM_W'(cls_r.mag) * NUM_W'(200) + NUM_W'(cls_r.den);
    d2_in.quo   = '0;
    d2_in.den2  = {cls_r.den, 1'b0};
    d2_in.ovf   = CMP2_W'(d2_in.acc) >= (CMP2_W'(d2_in.den2) << QUO_W);
    d2_in.neg   = cls_r.neg;
    d2_in.degen = cls_r.degen;
  end

  always_comb begin
    logic [CMP2_W-1:0] dsh;
    dsh = '0;
    for (int i = 0; i < QUO_W; i++) begin
      d2_nxt[i] = d2_r[i];
      dsh = CMP2_W'(d2_r[i].den2) << (QUO_W - 1 - i);
      if (CMP2_W'(d2_r[i].acc) >= dsh) begin
        d2_nxt[i].acc = NUM_W'(CMP2_W'(d2_r[i].acc) - dsh);
        d2_nxt[i].quo[QUO_W-1-i] = 1'b1;
      end
    end
  end

  always_comb begin
    logic [QUO_W-1:0] q;
    q = d2_r[QUO_W].quo;
    out_nxt.degenerate = d2_r[QUO_W].degen;
    out_nxt.saturated  = 1'b0;
    out_nxt.percent    = '0;
    priority if (d2_r[QUO_W].degen) begin
      out_nxt.percent = '0;
    end else if (d2_r[QUO_W].ovf) begin
      out_nxt.saturated = 1'b1;
      out_nxt.percent   = d2_r[QUO_W].neg ? PCT_MIN : PCT_MAX;
    end else if (!d2_r[QUO_W].neg) begin
      if (q > PCT_MAX) begin
        out_nxt.saturated = 1'b1;
        out_nxt.percent   = PCT_MAX;
      end else begin
        out_nxt.percent = q;
      end
    end else begin
      if (q > PCT_MIN) begin
        out_nxt.saturated = 1'b1;
        out_nxt.percent   = PCT_MIN;
      end else begin
        out_nxt.percent = 16'(-q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r  <= '0;
      bnd_v_r <= 1'b0;
      cls_v_r <= 1'b0;
      d2_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      d1_v_r  <= {d1_v_r[RATIO_W-1:0], in_valid};
      bnd_v_r <= d1_v_r[RATIO_W];
      cls_v_r <= bnd_v_r;
      d2_v_r  <= {d2_v_r[QUO_W-1:0], cls_v_r};
      out_v_r <= d2_v_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r[0] <= d1_in;
      for (int i = 0; i < RATIO_W; i++) begin
        d1_r[i+1] <= d1_nxt[i];
      end
      bnd_r   <= bnd_nxt;
      cls_r   <= cls_nxt;
      d2_r[0] <= d2_in;
      for (int i = 0; i < QUO_W; i++) begin
        d2_r[i+1] <= d2_nxt[i];
      end
      out_r <= out_nxt;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.degenerate |-> out_r.percent == '0 && !out_r.saturated)
    else $error("degenerate result carries a percent");

endmodule

### src/supply_compensated_pedal_scaling.sv
// Supply-compensated pedal position scaling.
// Input channel (in_valid/in_ready/in_data) takes one request per cycle while
// in_ready is high. A load request writes the zero and full percent sensor
// millivolts of one calibration point of one profile and produces no result.
// A convert request interpolates both bounds along the supply axis and returns
// one result on the output channel (out_valid/out_ready/out_data): rounded
// percent, saturated flag and degenerate flag.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets supply start,
// step and end; cfg_ready is always high. Write it only while the block is idle.
// Throughput: one request per cycle while in_ready is high. The ratio divider
// has 32 stages and the percent divider 16 stages. Loads take effect for every
// later convert.
// Reset (rst_n low, synchronous) empties the pipeline and restores the default
// supply settings; calibration points hold no value until loaded.
// When out_valid is high and out_ready low the back pipeline holds; the front
// keeps accepting until the 4-entry queue between them and both front stages
// are full, then in_ready drops.
module supply_compensated_pedal_scaling (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scps_pkg::scps_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scps_pkg::scps_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import scps_pkg::*;

  scps_cfg_t  cfg_r;
  logic       push_valid, push_ready;
  scps_item_t push_data;
  logic       pop_valid, pop_ready;
  scps_item_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.supply_start_mv <= SUPPLY_START_RST;
      cfg_r.supply_step_mv  <= SUPPLY_STEP_RST;
      cfg_r.supply_end_mv   <= SUPPLY_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SUPPLY_START: cfg_r.supply_start_mv <= cfg_data;
        CFG_SUPPLY_STEP:  cfg_r.supply_step_mv  <= cfg_data;
        CFG_SUPPLY_END:   cfg_r.supply_end_mv   <= cfg_data;
        default: ;
      endcase
    end
  end

  scps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  scps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  scps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .in_item   (pop_data),
    .step      (cfg_r.supply_step_mv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### verif/supply_compensated_pedal_scaling_test.sv
module supply_compensated_pedal_scaling_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scps_pkg::*;

  class pedal_scoreboard;
    logic [12:0] low_tbl [TBL_DEPTH];
    logic [12:0] high_tbl [TBL_DEPTH];
    logic [15:0] start_mv, step_mv, end_mv;
    scps_out_t pending_pct[$];
    int errors;

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_SUPPLY_START: start_mv = val;
        CFG_SUPPLY_STEP: step_mv = val;
        CFG_SUPPLY_END: end_mv = val;
        default: ;
      endcase
    endfunction

    function void note_request(scps_in_t req);
      longint sup, st, en, stp, off, seg, rem, ratio, lo, hi, s, num, den, mag, q;
      int base;
      scps_out_t res;
      if (req.op == OP_LOAD) begin
        if (req.point < POINTS) begin
          low_tbl[req.profile * POINTS + req.point] = req.cal_low_mv;
          high_tbl[req.profile * POINTS + req.point] = req.cal_high_mv;
        end
        return;
      end
      st = start_mv;
      en = end_mv;
      stp = (step_mv == 0) ? 1 : step_mv;
      sup = req.supply_mv;
      if (sup < st) sup = st;
      else if (sup > en) sup = en;
      off = sup - st;
      if (off < 0) off = 0;
      seg = off / stp;
      if (seg > POINTS - 2) seg = POINTS - 2;
      rem = off - seg * stp;
      ratio = (rem * 131072 + stp) / (2 * stp);
      base = req.profile * POINTS + int'(seg);
      lo = longint'(low_tbl[base]) * 65536
           + ratio * (longint'(low_tbl[base + 1]) - longint'(low_tbl[base]));
      hi = longint'(high_tbl[base]) * 65536
           + ratio * (longint'(high_tbl[base + 1]) - longint'(high_tbl[base]));
      s = longint'(req.sensor_mv) * 65536;
      res = '0;
      if (hi == lo) begin
        res.degenerate = 1'b1;
      end else begin
        if (hi > lo) begin
          num = 100 * (s - lo);
          den = hi - lo;
        end else begin
          num = 100 * (lo - s);
          den = lo - hi;
        end
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0) q = -q;
        if (q > 32767) begin
          q = 32767;
          res.saturated = 1'b1;
        end else if (q < -32768) begin
          q = -32768;
          res.saturated = 1'b1;
        end
        res.percent = q[15:0];
      end
      pending_pct.push_back(res);
    endfunction

    function void check_result(scps_out_t got);
      scps_out_t exp;
      if (pending_pct.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending_pct.pop_front();
      if (got.percent !== exp.percent) begin
        $display("%0t: percent exp %0d act %0d", $time, exp.percent, got.percent);
        errors++;
      end
      if (got.saturated !== exp.saturated) begin
        $display("%0t: saturated exp %b act %b", $time, exp.saturated, got.saturated);
        errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $display("%0t: degenerate exp %b act %b", $time, exp.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  scps_in_t in_data;
  scps_out_t out_data;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  pedal_scoreboard sb;
  bit long_hold;
  int cycles;

  supply_compensated_pedal_scaling dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  initial begin
    int r;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(30, 120)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_request(scps_in_t req);
    int r, gap;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    r = $urandom_range(0, 99);
    gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pct.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic scps_in_t load_req(bit prof, logic [2:0] pt,
                                        logic [12:0] lo, logic [12:0] hi);
    scps_in_t q;
    q = scps_in_t'(60'({$urandom, $urandom}));
    q.op = OP_LOAD;
    q.profile = prof;
    q.point = pt;
    q.cal_low_mv = lo;
    q.cal_high_mv = hi;
    return q;
  endfunction

  function automatic scps_in_t convert_req(bit prof, logic [12:0] sens, logic [15:0] sup);
    scps_in_t q;
    q = scps_in_t'(60'({$urandom, $urandom}));
    q.op = OP_CONVERT;
    q.profile = prof;
    q.sensor_mv = sens;
    q.supply_mv = sup;
    return q;
  endfunction

  function automatic scps_in_t random_req();
    int r;
    logic [12:0] lo, hi;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      lo = 13'($urandom_range(0, 8191));
      case ($urandom_range(0, 3))
        0: hi = lo;
        1: hi = lo + 13'($urandom_range(1, 3));
        default: hi = 13'($urandom_range(0, 8191));
      endcase
      return load_req(1'($urandom_range(0, 1)),
                      ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4)), lo, hi);
    end
    return convert_req(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) == 0) ? 13'(8191 * $urandom_range(0, 1))
                                                   : 13'($urandom_range(0, 8191)),
                       ($urandom_range(0, 1)) ? 16'($urandom_range(0, 65535))
                                              : 16'(sb.start_mv + $urandom_range(0, 5000)));
  endfunction

  initial begin
    logic [15:0] settings [7][3];
    sb = new();
    sb.start_mv = SUPPLY_START_RST;
    sb.step_mv = SUPPLY_STEP_RST;
    sb.end_mv = SUPPLY_END_RST;
    settings = '{'{16'd10000, 16'd1000, 16'd14000}, '{16'd0, 16'd1, 16'd65535},
                 '{16'd65535, 16'd65535, 16'd65535}, '{16'd0, 16'd0, 16'd65535},
                 '{16'd20000, 16'd100, 16'd5000}, '{16'd0, 16'd65535, 16'd0},
                 '{16'd1000, 16'd16000, 16'd65535}};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SUPPLY_START;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every point of both profiles is loaded before any convert
    for (int p = 0; p < PROFILES; p++)
      for (int i = 0; i < POINTS; i++)
        send_request(load_req(1'(p), 3'(i), (i == 0) ? 13'd0 : 13'(400 * i + 300 * p),
                              (i == 4) ? 13'd8191 : 13'(4000 - 200 * i)));
    send_request(load_req(1'b0, 3'd5, 13'd8191, 13'd8191));
    send_request(load_req(1'b1, 3'd7, 13'd0, 13'd0));
    send_request(convert_req(1'b0, 13'd0, 16'd0));
    send_request(convert_req(1'b0, 13'd8191, 16'd65535));
    send_request(convert_req(1'b1, 13'd2000, 16'd12500));
    send_request(convert_req(1'b1, 13'd8191, 16'd10000));
    send_request(convert_req(1'b0, 13'd4095, 16'd11499));
    send_request(load_req(1'b1, 3'd2, 13'd1000, 13'd1000));
    send_request(load_req(1'b1, 3'd3, 13'd1000, 13'd1000));
    send_request(convert_req(1'b1, 13'd500, 16'd12700));
    send_request(load_req(1'b0, 3'd1, 13'd100, 13'd101));
    send_request(convert_req(1'b0, 13'd8191, 16'd11000));
    send_request(convert_req(1'b0, 13'd0, 16'd11000));

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_reg(CFG_SUPPLY_START, settings[ph][0]);
      write_reg(CFG_SUPPLY_STEP, settings[ph][1]);
      write_reg(CFG_SUPPLY_END, settings[ph][2]);
      if (ph == 2) long_hold = 1;
      for (int n = 0; n < 230; n++) begin
        if (n == 115) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending_pct.size() != 0) @(posedge clk);
        end
        send_request(random_req());
      end
    end
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

### sim.f
src/scps_pkg.sv
src/scps_front.sv
src/scps_queue.sv
src/scps_back.sv
src/supply_compensated_pedal_scaling.sv
verif/supply_compensated_pedal_scaling_test.sv
